// ----- hw/rtl/c3s1a_pkg.sv -----
// ----------------------------------------------------------------------------
// c3s1a_pkg
// Shared constants and types for the 3x3 stride-1 accumulating convolution.
// ----------------------------------------------------------------------------
package c3s1a_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_OUT_PIXELS = 4096;
    localparam int MAX_CHANNELS   = 1024;
    localparam int PIXEL_BITS     = 16;
    localparam int TAPS           = 9;
    localparam int CFG_BITS       = 11;
    localparam int ACC_BITS       = 48;
    localparam int OIDX_BITS      = $clog2(MAX_OUT_PIXELS);
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int PROD_BITS      = 2 * PIXEL_BITS;
    localparam int Q_DEPTH        = 2;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    typedef logic signed [PIXEL_BITS-1:0] t_pix;

    // Work handed from the front end to the datapath: one complete window
    // with the kernel taps that were loaded when its pixel arrived.
    typedef struct packed {
        t_pix [TAPS-1:0]        win;
        t_pix [TAPS-1:0]        taps;
        logic [OIDX_BITS-1:0]   oidx;
        logic                   first_ch;
        logic                   emit;
        logic                   last;
    } t_job;

endpackage

// ----- hw/rtl/c3s1a_stream_if.sv -----
// ----------------------------------------------------------------------------
// c3s1a_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface c3s1a_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/c3s1a_front.sv -----
// ----------------------------------------------------------------------------
// c3s1a_front
// Decode words, hold taps, line stores and window; emit one job per complete window whose output index fits the store.
// ----------------------------------------------------------------------------
module c3s1a_front import c3s1a_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [CFG_BITS-1:0]  i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic [3:0]           i_weight_index,
    input  t_pix                 i_weight_value,
    input  t_pix                 i_pixel_value,
    input  logic                 i_space,
    output logic                 o_job_valid,
    output t_job                 o_job
);
    logic [CFG_BITS-1:0] r_w, r_h, r_c;
    logic [CFG_BITS-1:0] r_col, r_row, r_ch;
    t_pix [TAPS-1:0]     r_taps, r_win;
    // Line stores; columns below the fill count were written since reset.
    t_pix                r_up2 [MAX_WIDTH];
    t_pix                r_up1 [MAX_WIDTH];
    t_pix                r_rd2, r_rd1;
    logic [CFG_BITS-1:0] r_fill;
    logic                r_cfg_d;

    logic [CFG_BITS-1:0] w, h, ch, c, r, k, n_col, n_row, n_ch;
    logic [COL_BITS-1:0] ca, ra;
    logic                take;
    t_pix                up2, up1;
    logic [2*CFG_BITS-1:0] oidx_full;
    logic [CFG_BITS-1:0] ow;

    always_comb begin
        w  = (r_w < CFG_BITS'(3)) ? CFG_BITS'(3) :
             (r_w > CFG_BITS'(MAX_WIDTH)) ? CFG_BITS'(MAX_WIDTH) : r_w;
        h  = (r_h < CFG_BITS'(3)) ? CFG_BITS'(3) : r_h;
        ch = (r_c < CFG_BITS'(1)) ? CFG_BITS'(1) :
             (r_c > CFG_BITS'(MAX_CHANNELS)) ? CFG_BITS'(MAX_CHANNELS) : r_c;
        c  = (r_col >= w) ? '0 : r_col;
        r  = (r_row >= h) ? '0 : r_row;
        k  = (r_ch >= ch) ? '0 : r_ch;
        ca = c[COL_BITS-1:0];
        up2 = (c < r_fill) ? r_rd2 : '0;
        up1 = (c < r_fill) ? r_rd1 : '0;
        ow = w - CFG_BITS'(2);
        oidx_full = (2*CFG_BITS)'(r - CFG_BITS'(2)) * (2*CFG_BITS)'(ow)
                  + (2*CFG_BITS)'(c - CFG_BITS'(2));
        n_col = c + 1'b1;
        n_row = r;
        n_ch  = k;
        if (n_col >= w) begin
            n_col = '0;
            n_row = r + 1'b1;
            if (n_row >= h) begin
                n_row = '0;
                n_ch  = k + 1'b1;
                if (n_ch >= ch) n_ch = '0;
            end
        end
        // Prefetch the column that the next pixel will use.
        ra = (take && i_op == OP_PIXEL) ? n_col[COL_BITS-1:0] : ca;
    end

    // Hold input in the cycle after a register write so the prefetch catches up.
    assign o_ready = i_space && !r_cfg_d;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= CFG_BITS'(3); r_h <= CFG_BITS'(3); r_c <= CFG_BITS'(1);
            r_col <= '0; r_row <= '0; r_ch <= '0;
            r_taps <= '0; r_win <= '0;
            r_fill <= '0; r_cfg_d <= 1'b0;
            o_job_valid <= 1'b0;
        end else begin
            r_cfg_d <= i_cfg_we;
            o_job_valid <= take && i_op == OP_PIXEL
                        && (c >= CFG_BITS'(2)) && (r >= CFG_BITS'(2))
                        && (oidx_full < (2*CFG_BITS)'(MAX_OUT_PIXELS));
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WIDTH:    r_w <= i_cfg_data;
                    REG_HEIGHT:   r_h <= i_cfg_data;
                    REG_CHANNELS: r_c <= i_cfg_data;
                    default: ;
                endcase
            end
            if (take && i_op == OP_WEIGHT) begin
                if (i_weight_index < 4'(TAPS)) r_taps[i_weight_index] <= i_weight_value;
            end else if (take) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3]   <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3+2];
                end
                r_win[2] <= up2;
                r_win[5] <= up1;
                r_win[8] <= i_pixel_value;
                if (c == r_fill) r_fill <= r_fill + 1'b1;
                r_col <= n_col; r_row <= n_row; r_ch <= n_ch;
            end
        end
    end

    // Line store writes and job payload; window taps 2,5,8 go in fresh.
    always_ff @(posedge i_clk) begin
        if (take && i_op == OP_PIXEL) begin
            r_up2[ca] <= up1;
            r_up1[ca] <= i_pixel_value;
            o_job.win  <= {i_pixel_value, r_win[8], r_win[7], up1, r_win[5],
                           r_win[4], up2, r_win[2], r_win[1]};
            o_job.taps <= r_taps;
            o_job.oidx <= oidx_full[OIDX_BITS-1:0];
            o_job.first_ch <= (k == '0);
            o_job.emit <= (k == ch - 1'b1);
            o_job.last <= (r == h - 1'b1) && (c == w - 1'b1);
        end
        r_rd2 <= r_up2[ra];
        r_rd1 <= r_up1[ra];
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> $past(i_valid && i_space && i_op == OP_PIXEL))
        else $error("job without a pixel word");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < CFG_BITS'(MAX_WIDTH))
        else $error("column counter out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_space |-> !o_ready)
        else $error("accepted word without queue space");
endmodule

// ----- hw/rtl/c3s1a_queue.sv -----
// ----------------------------------------------------------------------------
// c3s1a_queue
// Small job queue between front end and datapath.
// ----------------------------------------------------------------------------
module c3s1a_queue import c3s1a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job,
    output logic [$clog2(Q_DEPTH+1)-1:0] o_count
);
    localparam int PB = $clog2(Q_DEPTH);
    t_job           r_mem [Q_DEPTH];
    logic [PB-1:0]  r_wp, r_rp;
    logic [$clog2(Q_DEPTH+1)-1:0] r_cnt;

    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PB'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PB'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ($clog2(Q_DEPTH+1))'(Q_DEPTH)) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == ($clog2(Q_DEPTH+1))'(Q_DEPTH) && !i_pop) |-> !i_push)
        else $error("push into full queue");
endmodule

// ----- hw/rtl/c3s1a_back.sv -----
// ----------------------------------------------------------------------------
// c3s1a_back
// Nine-tap multiply, adder tree, accumulator read-modify-write, output.
// ----------------------------------------------------------------------------
module c3s1a_back import c3s1a_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_job              i_job,
    output logic              o_pop,
    output logic [1:0]        o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [ACC_BITS-1:0] o_value,
    output logic [OIDX_BITS-1:0]       o_index,
    output logic              o_last
);
    // Stages: S1 products, S2 tree + accumulator read, S3 add/write, output.
    logic signed [PROD_BITS-1:0] r_prod [TAPS];
    logic [ACC_BITS-1:0] r_acc_mem [MAX_OUT_PIXELS];
    logic r_v1, r_v2, r_v3;
    t_job r_j1, r_j2;
    logic [ACC_BITS-1:0] r_dot, r_old, r_sum;
    logic [OIDX_BITS-1:0] r_idx3;
    logic r_emit3, r_last3;
    logic adv, fwd;
    logic [ACC_BITS-1:0] tree, old_fwd, sum;
    logic [ACC_BITS-1:0] ext [TAPS];
    logic [ACC_BITS-1:0] lvl1 [4];
    logic [ACC_BITS-1:0] lvl2 [2];

    // Output register frees as the word is taken; pipeline stalls as a whole.
    assign adv   = !o_valid || i_ready || !r_v3 || !r_emit3;
    assign o_pop = i_valid && adv;
    assign o_busy = 2'(r_v1) + 2'(r_v2);

    always_comb begin
        for (int i = 0; i < TAPS; i++)
            ext[i] = ACC_BITS'(r_prod[i]);
        for (int i = 0; i < 4; i++)
            lvl1[i] = ext[2*i] + ext[2*i+1];
        lvl2[0] = lvl1[0] + lvl1[1];
        lvl2[1] = lvl1[2] + lvl1[3];
        tree = lvl2[0] + lvl2[1] + ext[TAPS-1];
        sum = (r_j2.first_ch ? '0 : old_fwd) + r_dot;
    end
    // Bypass the sum written as this entry was read.
    assign fwd = r_v3 && r_idx3 == r_j2.oidx;
    assign old_fwd = fwd ? r_sum : r_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; o_valid <= 1'b0;
        end else begin
            if (adv && r_v3 && r_emit3) o_valid <= 1'b1;
            else if (o_valid && i_ready) o_valid <= 1'b0;
            if (adv) begin
                r_v1 <= i_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < TAPS; i++)
                r_prod[i] <= PROD_BITS'(i_job.win[i] * i_job.taps[i]);
            r_j1   <= i_job;
            r_j2   <= r_j1;
            r_dot  <= tree;
            r_old  <= r_acc_mem[r_j1.oidx];
            r_sum  <= sum;
            r_idx3 <= r_j2.oidx;
            r_emit3 <= r_j2.emit;
            r_last3 <= r_j2.last;
            if (r_v2) r_acc_mem[r_j2.oidx] <= sum;
            if (r_v3 && r_emit3) begin
                o_value <= r_sum;
                o_index <= r_idx3;
                o_last  <= r_last3;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && r_v3 && r_emit3) |-> !adv)
        else $error("pipeline advanced over a held result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid) else $error("pop without job");
endmodule

// ----- hw/rtl/conv3x3_stride1_accumulate.sv -----
// ----------------------------------------------------------------------------
// conv3x3_stride1_accumulate
// One output channel of a valid 3x3 stride-1 convolution over all inputs.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                  word
//  s_in      in   op, weight_index, weight_value, pixel    weight or pixel
//  m_out     out  out_value, out_index, last               finished sum
//  cfg       in   we, idx, data                            register write
//
//  One word per cycle sustained while m_out is ready; a pixel passes the
//  front register, queue, product, tree, accumulate and output registers. The
//  accumulator store is read and written through a separate read and write port.
//  Reset is synchronous; line stores read zero until written, tracked by a
//  fill count, no sweep. Taps travel with each job, so the next channel's
//  weights may load while earlier windows drain.
//  Input stalls when the queue plus the front register could overflow, and
//  in the cycle after a register write.
module conv3x3_stride1_accumulate import c3s1a_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    c3s1a_stream_if.sink        s_in,
    c3s1a_stream_if.source      m_out
);
    logic            job_valid, pop, q_valid, space;
    t_job            job, q_job;
    logic [$clog2(Q_DEPTH+1)-1:0] q_cnt;
    logic [1:0]      busy;

    // Hold input unless a slot is free counting the front register.
    assign space = (q_cnt + ($clog2(Q_DEPTH+1))'(job_valid)) <
                   ($clog2(Q_DEPTH+1))'(Q_DEPTH) || pop;

    c3s1a_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_op(s_in.data.op), .i_weight_index(s_in.data.weight_index),
        .i_weight_value(s_in.data.weight_value),
        .i_pixel_value(s_in.data.pixel_value),
        .i_space(space), .o_job_valid(job_valid), .o_job(job)
    );

    c3s1a_queue u_queue (
        .i_clk, .i_rst_n, .i_push(job_valid), .i_job(job), .i_pop(pop),
        .o_valid(q_valid), .o_job(q_job), .o_count(q_cnt)
    );

    c3s1a_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_job(q_job),
        .o_pop(pop), .o_busy(busy), .o_valid(m_out.valid), .i_ready(m_out.ready),
        .o_value(m_out.data.out_value), .o_index(m_out.data.out_index),
        .o_last(m_out.data.last)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy <= 2'd2) else $error("datapath occupancy out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid) else $error("datapath took from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_cnt == ($clog2(Q_DEPTH+1))'(Q_DEPTH) && job_valid) |-> pop)
        else $error("queue would overflow");
endmodule

// ----- bench/conv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv_checker
// Watches the pixel and result channels and the register port of the 3x3
// convolution, predicts each finished sum and compares it with the block.
// ----------------------------------------------------------------------------
package conv_bench_pkg;
    typedef struct packed {
        logic               op;
        logic [3:0]         weight_index;
        logic signed [15:0] weight_value;
        logic signed [15:0] pixel_value;
    } t_in_word;

    typedef struct packed {
        logic signed [47:0] out_value;
        logic [11:0]        out_index;
        logic               last;
    } t_out_word;
endpackage

module conv_checker import c3s1a_pkg::*; import conv_bench_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in_word            i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out_word           i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [10:0]        reg_w, reg_h, reg_c;
    logic signed [15:0] taps [TAPS];
    logic signed [15:0] win  [TAPS];
    logic signed [15:0] lines [2*MAX_WIDTH];
    logic signed [47:0] sums [MAX_OUT_PIXELS];
    int unsigned        col, row, chan;
    t_out_word          sum_queue [$];

    assign o_pending = sum_queue.size();

    function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    task automatic predict_sum(input t_in_word wd);
        int unsigned        w, h, c, ow, oc, orow, oidx;
        logic signed [31:0] prod;
        logic signed [47:0] dot;
        t_out_word          res;
        w = clampv(reg_w, 3, MAX_WIDTH);
        h = clampv(reg_h, 3, 2047);
        c = clampv(reg_c, 1, MAX_CHANNELS);
        if (wd.op == OP_WEIGHT) begin
            if (wd.weight_index < TAPS) taps[wd.weight_index] = wd.weight_value;
            return;
        end
        if (col >= w) col = 0;
        if (row >= h) row = 0;
        if (chan >= c) chan = 0;
        for (int i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = lines[col];
        win[5] = lines[MAX_WIDTH+col];
        win[8] = wd.pixel_value;
        lines[col] = lines[MAX_WIDTH+col];
        lines[MAX_WIDTH+col] = wd.pixel_value;
        if (col >= 2 && row >= 2) begin
            ow = w - 2; oc = col - 2; orow = row - 2;
            oidx = orow * ow + oc;
            if (oidx < MAX_OUT_PIXELS) begin
                dot = '0;
                for (int i = 0; i < TAPS; i++) begin
                    prod = win[i] * taps[i];
                    dot  = dot + 48'(prod);
                end
                sums[oidx] = (chan == 0) ? dot : sums[oidx] + dot;
                if (chan == c - 1) begin
                    res.out_value = sums[oidx];
                    res.out_index = oidx[11:0];
                    res.last      = (orow == h - 3 && oc == w - 3);
                    sum_queue.push_back(res);
                end
            end
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) begin
                row = 0;
                chan++;
                if (chan >= c) chan = 0;
            end
        end
    endtask

    task automatic report(input string what, input t_out_word exp_w, input t_out_word got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch %s: expected value %0d index %0d last %0d, got %0d %0d %0d",
                     what, exp_w.out_value, exp_w.out_index, exp_w.last,
                     got.out_value, got.out_index, got.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_w = 3; reg_h = 3; reg_c = 1;
            col = 0; row = 0; chan = 0;
            o_fail_count = 0;
            for (int i = 0; i < TAPS; i++) begin
                taps[i] = '0;
                win[i]  = '0;
            end
            for (int i = 0; i < 2*MAX_WIDTH; i++) lines[i] = '0;
        end else begin
            // compare first: no pixel can finish in the cycle it arrives
            if (i_out_valid && i_out_ready) begin
                if (sum_queue.size() == 0) begin
                    report("no sum waiting", '0, i_out_data);
                end else begin
                    t_out_word exp_w;
                    exp_w = sum_queue.pop_front();
                    if (exp_w.out_value !== i_out_data.out_value)
                        report("out_value", exp_w, i_out_data);
                    else if (exp_w.out_index !== i_out_data.out_index)
                        report("out_index", exp_w, i_out_data);
                    else if (exp_w.last !== i_out_data.last)
                        report("last", exp_w, i_out_data);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:    reg_w = i_cfg_data;
                    REG_HEIGHT:   reg_h = i_cfg_data;
                    REG_CHANNELS: reg_c = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_sum(i_in_data);
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives weight and pixel words through the convolution over several frame
// shapes and channel counts, with random gaps on both sides; the checker
// beside the block predicts every sum and reports the verdict's failures.
// ----------------------------------------------------------------------------
module testbench;
    import c3s1a_pkg::*;
    import conv_bench_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_idx;
    logic [CFG_BITS-1:0] cfg_data;
    int                  fail_count, pending;
    int                  words_sent;
    bit                  calm;   // no idling on either side while set

    c3s1a_stream_if #(.T(t_in_word))  in_ch ();
    c3s1a_stream_if #(.T(t_out_word)) out_ch ();

    conv3x3_stride1_accumulate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .s_in       (in_ch),
        .m_out      (out_ch)
    );

    conv_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Receiver: stall at random, about 28 in a hundred, never while calm.
    always @(negedge i_clk) begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
    end

    // Hand one word over; idle beforehand at random, hold until taken.
    task automatic put_word(input t_in_word wd);
        while (!calm && $urandom_range(99) < 28) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= wd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Drop valid, let every expected sum arrive, then allow the pipeline
    // its latency before the registers are touched.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_value(input int unsigned mode);
        case (mode)
            1: return 16'sh8000;
            2: return 16'sh7FFF;
            default: begin
                case ($urandom_range(7))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    default: return 16'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Configure and stream one full frame set: per channel nine taps in a
    // random order, then the pixels in raster order. Mode 1 and 2 force
    // the most negative and most positive values; noise adds stray loads,
    // some to taps beyond the kernel which the block must ignore.
    task automatic run_frames(input int unsigned w, input int unsigned h,
                              input int unsigned c, input int unsigned mode,
                              input bit noise);
        int unsigned ew, eh, ec, order [TAPS], j, tmp;
        t_in_word    wd;
        write_reg(REG_WIDTH,    w[CFG_BITS-1:0]);
        write_reg(REG_HEIGHT,   h[CFG_BITS-1:0]);
        write_reg(REG_CHANNELS, c[CFG_BITS-1:0]);
        ew = clampv(w, 3, MAX_WIDTH);
        eh = clampv(h, 3, 2047);
        ec = clampv(c, 1, MAX_CHANNELS);
        for (int ch = 0; ch < ec; ch++) begin
            for (int i = 0; i < TAPS; i++) order[i] = i;
            for (int i = TAPS - 1; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = order[i]; order[i] = order[j]; order[j] = tmp;
            end
            for (int i = 0; i < TAPS; i++) begin
                wd.op           = OP_WEIGHT;
                wd.weight_index = 4'(order[i]);
                wd.weight_value = pick_value(mode);
                wd.pixel_value  = 16'($urandom);
                put_word(wd);
            end
            for (int p = 0; p < ew * eh; p++) begin
                if (noise && $urandom_range(19) == 0) begin
                    wd.op           = OP_WEIGHT;
                    wd.weight_index = 4'($urandom_range(15));
                    wd.weight_value = pick_value(0);
                    wd.pixel_value  = 16'($urandom);
                    put_word(wd);
                end
                wd.op           = OP_PIXEL;
                wd.weight_index = 4'($urandom_range(15));
                wd.weight_value = 16'($urandom);
                wd.pixel_value  = pick_value(mode);
                put_word(wd);
            end
        end
        settle();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = REG_WIDTH;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        calm         = 1'b0;
        words_sent   = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: smallest map with all-negative and all-positive extremes
        run_frames(3, 3, 1, 1, 1'b0);
        run_frames(3, 3, 1, 2, 1'b0);
        // registers below range clamp to the smallest shape
        run_frames(0, 1, 0, 0, 1'b1);
        // extremes summed over two channels, then a wider multichannel map
        run_frames(4, 3, 2, 1, 1'b0);
        run_frames(6, 4, 3, 0, 1'b1);

        // random shapes; one stretch runs with no idling at all
        for (int f = 0; words_sent < 700 || f < 6; f++) begin
            calm = (f >= 1 && f < 5);
            run_frames($urandom_range(9), $urandom_range(9), $urandom_range(3),
                       0, 1'($urandom_range(1)));
        end
        calm = 1'b0;

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
